// ===== design/assert_macros.svh =====
// Assertion helpers shared by the escaper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== design/cse_pkg.sv =====
package cse_pkg;

  // Column handling
  localparam logic [6:0] COL_START   = 7'd3;
  localparam logic [6:0] COL_MAX     = 7'd127;
  localparam logic [6:0] WRAP_RESET  = 7'd70;

  // Byte classification bounds
  localparam logic [7:0] PRINT_LO    = 8'd33;
  localparam logic [7:0] PRINT_HI    = 8'd126;
  localparam logic [7:0] OCT_ONE_MAX = 8'd7;
  localparam logic [7:0] OCT_TWO_MAX = 8'd63;

  // ASCII characters that the encoder emits
  localparam logic [6:0] CH_QUOTE    = 7'h22;
  localparam logic [6:0] CH_NEWLINE  = 7'h0A;
  localparam logic [6:0] CH_SPACE    = 7'h20;
  localparam logic [6:0] CH_BSLASH   = 7'h5C;
  localparam logic [6:0] CH_ZERO     = 7'h30;
  localparam logic [6:0] CH_NINE     = 7'h39;

  // Length of the line break sequence, minus one
  localparam logic [2:0] BRK_LAST    = 3'd4;

  // Queue depth between classifier and emitter
  localparam int QDEPTH = 4;

  // Encoding kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PLAIN = 2'd0;
  localparam kind_t KIND_ESC   = 2'd1;
  localparam kind_t KIND_GUARD = 2'd2;
  localparam kind_t KIND_OCT   = 2'd3;

  // One classified byte on its way to the emitter
  typedef struct packed {
    logic       brk;
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  // Characters of the line break: quote, newline, two spaces, quote
  function automatic logic [6:0] brk_char(input logic [2:0] idx);
    logic [6:0] c;
    case (idx)
      3'd1:    c = CH_NEWLINE;
      3'd2:    c = CH_SPACE;
      3'd3:    c = CH_SPACE;
      default: c = CH_QUOTE;
    endcase
    return c;
  endfunction

endpackage

// ===== design/byte_to_c_string_literal_escaper_core.sv =====
// Encodes raw bytes into the text of a double-quoted C string literal, one
// ASCII character per output request, with last set on the final character
// of each byte. Output runs at one character per clock while out_stall is
// low: a printable byte gives 1 character, an escaped quote or backslash 2,
// a guarded digit 3, an octal escape 2 to 4, and a line break adds 5 more,
// so a byte costs 1 to 9 characters and the output port sets the sustained
// rate. Input takes one byte per clock while the Depth-entry queue ahead of
// the character emitter has room; a byte passes the queue, current-item and
// output registers. User must write wrap_column via the cfg port only while
// the block is idle, which it does not enforce. cfg_ready is always high.
module byte_to_c_string_literal_escaper_core #(
  parameter int Depth = cse_pkg::QDEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] wrap_column,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       last
);

  logic           push;
  cse_pkg::item_t push_item;
  logic           pop;
  logic           q_valid;
  logic           q_full;
  cse_pkg::item_t q_item;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  cse_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .wrap_column (wrap_column),
    .in_valid    (in_valid),
    .data_byte   (data_byte),
    .restart     (restart),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  cse_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  cse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

// ===== design/cse_front.sv =====
`include "assert_macros.svh"

module cse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [6:0]        wrap_column,
  input  logic              in_valid,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  input  logic              q_full,
  output logic              push,
  output cse_pkg::item_t    push_item
);

  logic [6:0] wrap;
  logic [6:0] column;
  logic       digit_guard;
  logic [6:0] column_next;
  logic       digit_guard_next;

  logic [6:0] col_eff;
  logic       guard_eff;
  logic       brk;
  logic [6:0] col_base;
  logic       guard_base;
  logic       is_oct;
  logic       is_digit;
  cse_pkg::kind_t kind;
  logic [2:0] adv;
  logic [7:0] col_sum;

  // Store the wrap limit
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap <= cse_pkg::WRAP_RESET;
    end else if (cfg_valid) begin
      wrap <= wrap_column;
    end
  end

  assign push = in_valid && !q_full;

  // Classify the byte and work out the column it leaves behind
  always_comb begin
    col_eff    = restart ? cse_pkg::COL_START : column;
    guard_eff  = restart ? 1'b0 : digit_guard;
    brk        = col_eff > wrap;
    col_base   = brk ? cse_pkg::COL_START : col_eff;
    guard_base = brk ? 1'b0 : guard_eff;
    is_oct     = (data_byte < cse_pkg::PRINT_LO) || (data_byte > cse_pkg::PRINT_HI);
    is_digit   = (data_byte[6:0] >= cse_pkg::CH_ZERO) && (data_byte[6:0] <= cse_pkg::CH_NINE)
                 && !data_byte[7];
    if (is_oct) begin
      kind = cse_pkg::KIND_OCT;
      adv  = 3'd2 + {2'b0, data_byte > cse_pkg::OCT_ONE_MAX}
                  + {2'b0, data_byte > cse_pkg::OCT_TWO_MAX};
    end else if ((data_byte[6:0] == cse_pkg::CH_BSLASH)
                 || (data_byte[6:0] == cse_pkg::CH_QUOTE)) begin
      kind = cse_pkg::KIND_ESC;
      adv  = 3'd2;
    end else if (guard_base && is_digit) begin
      kind = cse_pkg::KIND_GUARD;
      adv  = 3'd3;
    end else begin
      kind = cse_pkg::KIND_PLAIN;
      adv  = 3'd1;
    end
    col_sum          = {1'b0, col_base} + {5'b0, adv};
    column_next      = col_sum[7] ? cse_pkg::COL_MAX : col_sum[6:0];
    digit_guard_next = is_oct && (data_byte <= cse_pkg::OCT_TWO_MAX);
  end

  assign push_item.brk  = brk;
  assign push_item.kind = kind;
  assign push_item.data = data_byte;

  // Advance column state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= cse_pkg::COL_START;
      digit_guard <= 1'b0;
    end else if (push) begin
      column      <= column_next;
      digit_guard <= digit_guard_next;
    end
  end

  `ASSERT_NEVER(a_col_floor, clk, rst, column < cse_pkg::COL_START)
  `ASSERT_CLK(a_guard_after_short_oct, clk, rst,
              $past(push && !rst) |-> (digit_guard == $past((push_item.kind == cse_pkg::KIND_OCT) && (data_byte <= cse_pkg::OCT_TWO_MAX))))

endmodule

// ===== design/cse_queue.sv =====
`include "assert_macros.svh"

module cse_queue #(
  parameter int Depth = cse_pkg::QDEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cse_pkg::item_t push_item,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output cse_pkg::item_t q_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cse_pkg::item_t slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign q_valid = count != '0;
  assign q_full  = count == CntW'(Depth);
  assign q_item  = slots[rd_ptr];

  // Write the request into its slot
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && q_full)
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && !q_valid)

endmodule

// ===== design/cse_back.sv =====
`include "assert_macros.svh"

module cse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  cse_pkg::item_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [6:0]     out_char,
  output logic           last
);

  logic           cur_valid;
  cse_pkg::item_t cur;
  logic           in_brk;
  logic [2:0]     brk_cnt;
  logic [1:0]     body_idx;

  logic [1:0] top_digit;
  logic [1:0] body_last;
  logic [1:0] shift;
  logic [2:0] digit;
  logic [6:0] ch;
  logic       ch_last;
  logic       out_ready;
  logic       adv;
  logic       load;

  // Pick the character for the current step
  always_comb begin
    top_digit = (cur.data > cse_pkg::OCT_TWO_MAX) ? 2'd2 :
                (cur.data > cse_pkg::OCT_ONE_MAX) ? 2'd1 : 2'd0;
    shift = top_digit + 2'd1 - body_idx;
    case (shift)
      2'd2:    digit = {1'b0, cur.data[7:6]};
      2'd1:    digit = cur.data[5:3];
      default: digit = cur.data[2:0];
    endcase
    unique case (cur.kind)
      cse_pkg::KIND_OCT: begin
        body_last = top_digit + 2'd1;
        ch = (body_idx == 2'd0) ? cse_pkg::CH_BSLASH : cse_pkg::CH_ZERO + {4'b0, digit};
      end
      cse_pkg::KIND_ESC: begin
        body_last = 2'd1;
        ch = (body_idx == 2'd0) ? cse_pkg::CH_BSLASH : cur.data[6:0];
      end
      cse_pkg::KIND_GUARD: begin
        body_last = 2'd2;
        ch = (body_idx < 2'd2) ? cse_pkg::CH_QUOTE : cur.data[6:0];
      end
      default: begin
        body_last = 2'd0;
        ch = cur.data[6:0];
      end
    endcase
    if (in_brk) begin
      ch = cse_pkg::brk_char(brk_cnt);
    end
    ch_last = !in_brk && (body_idx == body_last);
  end

  assign out_ready = !out_valid || !out_stall;
  assign adv       = cur_valid && out_ready;
  assign load      = !cur_valid || (adv && ch_last);
  assign pop       = load && q_valid;

  // Hold the request being emitted and step through its characters
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      in_brk    <= 1'b0;
      brk_cnt   <= '0;
      body_idx  <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      in_brk    <= q_item.brk;
      brk_cnt   <= '0;
      body_idx  <= '0;
    end else if (adv) begin
      if (ch_last) begin
        cur_valid <= 1'b0;
      end else if (in_brk) begin
        if (brk_cnt == cse_pkg::BRK_LAST) begin
          in_brk <= 1'b0;
        end else begin
          brk_cnt <= brk_cnt + 3'd1;
        end
      end else begin
        body_idx <= body_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_char <= ch;
      last     <= ch_last;
    end
  end

  `ASSERT_NEVER(a_brk_before_body, clk, rst, cur_valid && in_brk && body_idx != 2'd0)
  `ASSERT_NEVER(a_brk_count_range, clk, rst, cur_valid && in_brk && brk_cnt > cse_pkg::BRK_LAST)

endmodule

// ===== dv/byte_to_c_string_literal_escaper_core_test.sv =====
`timescale 1ns / 100ps
module byte_to_c_string_literal_escaper_core_test;

  // One character of literal text, with the end-of-byte mark
  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
  } lit_char_t;

  // One raw byte request for the input channel
  typedef struct packed {
    logic [7:0] b;
    logic       rs;
  } raw_byte_t;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 72;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] wrap_column = cse_pkg::WRAP_RESET;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'd0;
  logic       restart = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_char;
  logic       last;

  raw_byte_t pending_bytes[$];
  raw_byte_t next_byte;
  lit_char_t literal_text[$];
  lit_char_t want;

  // Predictor state
  logic [6:0] wrap_limit = cse_pkg::WRAP_RESET;
  logic [6:0] line_col = cse_pkg::COL_START;
  logic       after_short_oct = 1'b0;

  int send_idle_pct = 13;
  int recv_stall_pct = 56;
  int restart_pct = 5;
  int send_calm = 0;
  int recv_calm = 0;
  int errors = 0;
  int bytes_sent = 0;
  int chars_checked = 0;
  int breaks_made = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  byte_to_c_string_literal_escaper_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .wrap_column (wrap_column),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last        (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expand one byte into the literal characters it must produce
  task automatic encode_byte(input raw_byte_t rb);
    logic [6:0] seq[$];
    int step;
    if (rb.rs) begin
      line_col = cse_pkg::COL_START;
      after_short_oct = 1'b0;
    end
    // close and reopen the literal on a new line
    if (line_col > wrap_limit) begin
      seq.push_back(cse_pkg::CH_QUOTE);
      seq.push_back(cse_pkg::CH_NEWLINE);
      seq.push_back(cse_pkg::CH_SPACE);
      seq.push_back(cse_pkg::CH_SPACE);
      seq.push_back(cse_pkg::CH_QUOTE);
      line_col = cse_pkg::COL_START;
      after_short_oct = 1'b0;
      breaks_made++;
    end
    if (rb.b < cse_pkg::PRINT_LO || rb.b > cse_pkg::PRINT_HI) begin
      // shortest octal escape
      seq.push_back(cse_pkg::CH_BSLASH);
      if (rb.b > cse_pkg::OCT_TWO_MAX) seq.push_back(cse_pkg::CH_ZERO + 7'(rb.b[7:6]));
      if (rb.b > cse_pkg::OCT_ONE_MAX) seq.push_back(cse_pkg::CH_ZERO + 7'(rb.b[5:3]));
      seq.push_back(cse_pkg::CH_ZERO + 7'(rb.b[2:0]));
      step = 2 + int'(rb.b > cse_pkg::OCT_ONE_MAX) + int'(rb.b > cse_pkg::OCT_TWO_MAX);
      after_short_oct = (rb.b <= cse_pkg::OCT_TWO_MAX);
    end else begin
      if (rb.b[6:0] == cse_pkg::CH_BSLASH || rb.b[6:0] == cse_pkg::CH_QUOTE) begin
        seq.push_back(cse_pkg::CH_BSLASH);
        seq.push_back(rb.b[6:0]);
        step = 2;
      end else if (after_short_oct && rb.b[6:0] >= cse_pkg::CH_ZERO
                   && rb.b[6:0] <= cse_pkg::CH_NINE) begin
        // split the literal so the digit is not read as part of the escape
        seq.push_back(cse_pkg::CH_QUOTE);
        seq.push_back(cse_pkg::CH_QUOTE);
        seq.push_back(rb.b[6:0]);
        step = 3;
      end else begin
        seq.push_back(rb.b[6:0]);
        step = 1;
      end
      after_short_oct = 1'b0;
    end
    // advance the column, saturating at the top
    if (int'(line_col) + step > int'(cse_pkg::COL_MAX)) line_col = cse_pkg::COL_MAX;
    else line_col = 7'(int'(line_col) + step);
    foreach (seq[i]) literal_text.push_back(lit_char_t'{seq[i], i == seq.size() - 1});
  endtask

  // Pick a byte weighted toward the interesting classes
  function automatic raw_byte_t pick_byte();
    raw_byte_t rb;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) rb.b = 8'($urandom_range(33, 126));
    else if (r < 55) rb.b = 8'($urandom_range(48, 57));
    else if (r < 70) rb.b = 8'($urandom_range(0, 63));
    else if (r < 85) rb.b = 8'($urandom_range(127, 255));
    else if (r < 93) rb.b = ($urandom_range(0, 1) != 0) ? {1'b0, cse_pkg::CH_BSLASH}
                                                        : {1'b0, cse_pkg::CH_QUOTE};
    else rb.b = 8'($urandom_range(0, 255));
    rb.rs = ($urandom_range(0, 99) < restart_pct);
    return rb;
  endfunction

  // Input driver: hold the request while stalled, otherwise advance or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(raw_byte_t'{data_byte, restart});
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(10, 40);
        if (pending_bytes.size() > 0 &&
            (send_calm > 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
          next_byte = pending_bytes.pop_front();
          in_valid  <= 1'b1;
          data_byte <= next_byte.b;
          restart   <= next_byte.rs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each character against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (literal_text.size() == 0) begin
          $display("%0t: unexpected char expected none actual char=%02h last=%0b",
                   $time, out_char, last);
          errors++;
        end else begin
          want = literal_text.pop_front();
          chars_checked++;
          if (out_char !== want.ch) begin
            $display("%0t: out_char mismatch expected %02h actual %02h",
                     $time, want.ch, out_char);
            errors++;
          end
          if (last !== want.fin) begin
            $display("%0t: last mismatch expected %0b actual %0b", $time, want.fin, last);
            errors++;
          end
        end
      end
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(10, 40);
      out_stall <= (recv_calm == 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: drop the run if no request moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write the wrap column; called at a clock edge while the block is idle
  task automatic write_wrap(input logic [6:0] v);
    cfg_valid   <= 1'b1;
    wrap_column <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    wrap_limit = v;
    settings_used++;
    cfg_valid <= 1'b0;
  endtask

  // Wait until every byte is taken and every character has come back
  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid || literal_text.size() > 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] directed_vals [24];
    logic [6:0] wrap_plan [PHASES];
    int ph;
    directed_vals = '{8'd0, 8'd255, 8'd7, 8'd8, 8'd63, 8'd64, 8'd32, 8'd33,
                      8'd126, 8'd127, 8'h5C, 8'h22, 8'd1, 8'h35, 8'd63, 8'h39,
                      8'd64, 8'h30, 8'd7, 8'h30, 8'd2, 8'h33, 8'h41, 8'd128};
    wrap_plan = '{7'd8, 7'd120, 7'd127, 7'd0, 7'($urandom_range(9, 119)),
                  cse_pkg::WRAP_RESET};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed bytes at the reset wrap column; restart clears the digit guard
    foreach (directed_vals[i])
      pending_bytes.push_back(raw_byte_t'{directed_vals[i], i == 0 || i == 21});
    @(posedge clk);
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct  = 13;
        recv_stall_pct = 56;
      end else if (ph < 4) begin
        send_idle_pct  = 56;
        recv_stall_pct = 13;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      // no restarts at the top wrap so the column reaches saturation
      restart_pct = (wrap_plan[ph] == cse_pkg::COL_MAX) ? 0 : 5;
      write_wrap(wrap_plan[ph]);
      repeat (PHASE_BYTES) pending_bytes.push_back(pick_byte());
      @(posedge clk);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d bytes under %0d wrap settings, including 0 and 127.",
             bytes_sent, settings_used);
    $display("Checked %0d characters, %0d line breaks, %0d errors.",
             chars_checked, breaks_made, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== byte_to_c_string_literal_escaper_core.f =====
+incdir+design
design/cse_pkg.sv
design/cse_front.sv
design/cse_queue.sv
design/cse_back.sv
design/byte_to_c_string_literal_escaper_core.sv
dv/byte_to_c_string_literal_escaper_core_test.sv
